// ===== rtl/core/button_debounce_press_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_assert.svh
// Assertion macros used by the debounce classifier RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge
`define BDPC_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define BDPC_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // configuration register file
  localparam int REG_W    = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [REG_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [REG_W-1:0] LONG_PRESS_RESET = 16'd1000;

  // register select taken from paddr[2]
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  // raw level encoding (active low)
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  // press events
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_LONG   = 2'd2
  } event_t;

  // one result beat
  typedef struct packed {
    event_t event_res;
    logic   pressed;
  } result_t;

endpackage

// ===== rtl/core/bdpc_classify.sv =====
// ----------------------------------------------------------------------------
// bdpc_classify
// Debounce and hold-time state; computes one result per sample and
// commits the state update when step is high.
// ----------------------------------------------------------------------------
module bdpc_classify #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         level,
  input  logic [bdpc_pkg::REG_W-1:0]   debounce_ticks,
  input  logic [bdpc_pkg::REG_W-1:0]   long_press_ticks,
  output bdpc_pkg::result_t            res
);

  localparam int CMP_W = (COUNT_WIDTH > bdpc_pkg::REG_W) ? COUNT_WIDTH : bdpc_pkg::REG_W;

  logic                   raw_previous;
  logic                   stable_level;
  logic [COUNT_WIDTH-1:0] quiet_ticks;
  logic [COUNT_WIDTH-1:0] hold_ticks;
  logic                   press_active;

  logic                   stable_level_next;
  logic [COUNT_WIDTH-1:0] quiet_ticks_next;
  logic [COUNT_WIDTH-1:0] hold_ticks_next;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic                   press_active_next;
  logic                   take_level;
  bdpc_pkg::event_t       ev;

  // next-state and result for the current sample
  always_comb begin
    // quiet counter: restart on a raw edge, else saturating count
    if (level != raw_previous) begin
      quiet_ticks_next = '0;
    end else if (quiet_ticks == {COUNT_WIDTH{1'b1}}) begin
      quiet_ticks_next = quiet_ticks;
    end else begin
      quiet_ticks_next = quiet_ticks + COUNT_WIDTH'(1);
    end

    // hold counter runs while a press is active
    if (press_active && (hold_ticks != {COUNT_WIDTH{1'b1}})) begin
      hold_inc = hold_ticks + COUNT_WIDTH'(1);
    end else begin
      hold_inc = hold_ticks;
    end

    take_level = (CMP_W'(quiet_ticks_next) > CMP_W'(debounce_ticks))
                 && (level != stable_level);

    stable_level_next = stable_level;
    press_active_next = press_active;
    hold_ticks_next   = hold_inc;
    ev                = bdpc_pkg::EV_NONE;

    if (take_level) begin
      stable_level_next = level;
      hold_ticks_next   = '0;
      if (level == bdpc_pkg::LEVEL_PRESSED) begin
        press_active_next = 1'b1;
      end else begin
        press_active_next = 1'b0;
        if (press_active && (CMP_W'(hold_inc) >= CMP_W'(long_press_ticks))) begin
          ev = bdpc_pkg::EV_LONG;
        end else begin
          ev = bdpc_pkg::EV_SINGLE;
        end
      end
    end
  end

  assign res.event_res = ev;
  assign res.pressed   = (stable_level_next == bdpc_pkg::LEVEL_PRESSED);

  // state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous <= bdpc_pkg::LEVEL_RELEASED;
      stable_level <= bdpc_pkg::LEVEL_RELEASED;
      quiet_ticks  <= '0;
      hold_ticks   <= '0;
      press_active <= 1'b0;
    end else if (step) begin
      raw_previous <= level;
      stable_level <= stable_level_next;
      quiet_ticks  <= quiet_ticks_next;
      hold_ticks   <= hold_ticks_next;
      press_active <= press_active_next;
    end
  end

endmodule

// ===== rtl/core/button_debounce_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier: debounce and single/long press events
// Pipeline: input register, combinational classification, result register.
// Throughput: one beat per cycle unless out_stall holds the result; the state commits once per advancing beat.
// Reset: counters clear, levels read released, registers load 50 and 1000.
// ----------------------------------------------------------------------------
`include "button_debounce_press_classifier_assert.svh"

module button_debounce_press_classifier #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          level,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    event_res,
  output logic                          pressed,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdpc_pkg::APB_AW-1:0]   paddr,
  input  logic [bdpc_pkg::APB_DW-1:0]   pwdata,
  output logic [bdpc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [bdpc_pkg::REG_W-1:0] debounce_ticks;
  logic [bdpc_pkg::REG_W-1:0] long_press_ticks;

  logic              s1_valid;
  logic              s1_level;
  logic              out_free;
  logic              advance;
  bdpc_pkg::result_t res;
  bdpc_pkg::result_t out_res;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bdpc_pkg::DEBOUNCE_RESET;
      long_press_ticks <= bdpc_pkg::LONG_PRESS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        bdpc_pkg::REG_DEBOUNCE:   debounce_ticks   <= pwdata[bdpc_pkg::REG_W-1:0];
        bdpc_pkg::REG_LONG_PRESS: long_press_ticks <= pwdata[bdpc_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bdpc_pkg::REG_DEBOUNCE:   prdata = bdpc_pkg::APB_DW'(debounce_ticks);
      bdpc_pkg::REG_LONG_PRESS: prdata = bdpc_pkg::APB_DW'(long_press_ticks);
      default:                  prdata = '0;
    endcase
  end

  // pipeline flow control
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_level <= level;
    end
  end

  // debounce state and classification
  bdpc_classify #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_classify (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .level            (s1_level),
    .debounce_ticks   (debounce_ticks),
    .long_press_ticks (long_press_ticks),
    .res              (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign event_res = out_res.event_res;
  assign pressed   = out_res.pressed;

  // checks
  `BDPC_ASSERT_NOW(a_event_means_released, clk, rst,
                   out_valid && (event_res != bdpc_pkg::EV_NONE), !pressed)
  `BDPC_ASSERT_NOW(a_event_code_legal, clk, rst, out_valid,
                   (event_res == bdpc_pkg::EV_NONE) || (event_res == bdpc_pkg::EV_SINGLE)
                   || (event_res == bdpc_pkg::EV_LONG))
  `BDPC_ASSERT_NEXT(a_advance_gives_beat, clk, rst, advance, out_valid)

endmodule
